// ===== hw/rtl/cfp_pkg.sv =====
// ---------------------------------------------------------------------------
// cfp_pkg: shared types and constants of the coordinate frame parser
// Frame character codes, value limits and the queue status bundle.
// ---------------------------------------------------------------------------
package cfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 10;
    localparam int OUT_W   = 24;

    localparam logic [BYTE_W-1:0] CH_HEAD = 8'h40;  // '@'
    localparam logic [BYTE_W-1:0] CH_SEP  = 8'h2A;  // '*'
    localparam logic [BYTE_W-1:0] CH_END  = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] CH_TAIL = 8'h23;  // '#'
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;  // '9'

    localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd1023;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hw/rtl/coordinate_frame_parser_unit.sv =====
// ---------------------------------------------------------------------------
// coordinate_frame_parser_unit: coordinate frame parser
// Parses '@' X '*' Y '$' C '#' frames and reports one result per frame.
// ---------------------------------------------------------------------------
// Takes one received byte per cycle and gives one result word for each '#'
// that closes a frame. The frame record is written into a two-entry queue
// at the edge that takes the '#', and the evaluator loads its output
// register from the queue head once that register is empty or its word is
// being taken. Input is throttled only when that queue is full, which needs
// the output to stall across three whole frames (one in the output register,
// two in the queue). A word holds the pass flag of the frame, the held X and
// Y coordinates (updated only by frames that pass the length and check byte
// tests) and the seen flag, which is cleared by a passing frame whose
// coordinates are both zero.
module coordinate_frame_parser_unit #(
    parameter int FIELD_DIGITS = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cfp_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] frame_ok, [10:1] x_value, [20:11] y_value, [21] target_seen, [23:22] zero
    output logic [cfp_pkg::OUT_W-1:0]     m_tdata
);

    localparam int FIELD_W = FIELD_DIGITS * cfp_pkg::BYTE_W;
    localparam int REC_W   = 1 + 2 * FIELD_W + cfp_pkg::BYTE_W;

    cfp_pkg::q_status_t                           q_stat;
    logic                                         push;
    logic                                         pop;
    logic                                         f_len_ok;
    logic [FIELD_DIGITS-1:0][cfp_pkg::BYTE_W-1:0] f_x_chars, f_y_chars;
    logic [cfp_pkg::BYTE_W-1:0]                   f_check;
    logic [REC_W-1:0]                             rec_in, rec_out;
    logic                                         b_len_ok;
    logic [FIELD_DIGITS-1:0][cfp_pkg::BYTE_W-1:0] b_x_chars, b_y_chars;
    logic [cfp_pkg::BYTE_W-1:0]                   b_check;

    cfp_front #(
        .FIELD_DIGITS(FIELD_DIGITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_stat     (q_stat),
        .push       (push),
        .len_ok     (f_len_ok),
        .x_chars    (f_x_chars),
        .y_chars    (f_y_chars),
        .check_byte (f_check)
    );

    assign rec_in = {f_len_ok, f_x_chars, f_y_chars, f_check};

    cfp_fifo #(
        .WIDTH(REC_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (rec_in),
        .pop       (pop),
        .pop_data  (rec_out),
        .q_stat    (q_stat)
    );

    assign {b_len_ok, b_x_chars, b_y_chars, b_check} = rec_out;

    cfp_back #(
        .FIELD_DIGITS(FIELD_DIGITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .pop        (pop),
        .len_ok     (b_len_ok),
        .x_chars    (b_x_chars),
        .y_chars    (b_y_chars),
        .check_byte (b_check),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

`ifndef SYNTHESIS
    // a passing frame with both coordinates zero clears the seen flag
    a_seen_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0] && m_tdata[20:1] == 20'd0) |-> !m_tdata[21])
        else $error("seen flag set after all-zero frame");

    // a passing frame with a nonzero coordinate sets the seen flag
    a_seen_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0] && m_tdata[20:1] != 20'd0) |-> m_tdata[21])
        else $error("seen flag clear after nonzero frame");

    // the queue never reports full and empty together
    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

    // a frame record is never pushed into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("frame record pushed into full queue");
`endif

endmodule

// ===== hw/rtl/cfp_front.sv =====
// ---------------------------------------------------------------------------
// cfp_front: frame tracker
// Accepts bytes, follows the frame phases, buffers the field characters and
// the check byte, and pushes one frame record into the queue on each '#' that closes a frame.
// ---------------------------------------------------------------------------
module cfp_front #(
    parameter int FIELD_DIGITS = 3
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [cfp_pkg::BYTE_W-1:0]                    s_tdata,
    input  cfp_pkg::q_status_t                            q_stat,
    output logic                                          push,
    output logic                                          len_ok,
    output logic [FIELD_DIGITS-1:0][cfp_pkg::BYTE_W-1:0]  x_chars,
    output logic [FIELD_DIGITS-1:0][cfp_pkg::BYTE_W-1:0]  y_chars,
    output logic [cfp_pkg::BYTE_W-1:0]                    check_byte
);

    localparam int CNT_W = $clog2(FIELD_DIGITS + 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIELD_DIGITS);
    localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(FIELD_DIGITS + 1);

    localparam logic [1:0] PH_HEAD  = 2'd0;
    localparam logic [1:0] PH_X     = 2'd1;
    localparam logic [1:0] PH_Y     = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    logic [1:0]                                  phase_reg, phase_next;
    logic [CNT_W-1:0]                            x_count_reg, x_count_next;
    logic [CNT_W-1:0]                            y_count_reg, y_count_next;
    logic [cfp_pkg::BYTE_W-1:0]                  check_reg, check_next;
    logic [FIELD_DIGITS-1:0][cfp_pkg::BYTE_W-1:0] x_chars_reg, y_chars_reg;
    logic                                        accept;
    logic                                        x_put, y_put;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        phase_next   = phase_reg;
        x_count_next = x_count_reg;
        y_count_next = y_count_reg;
        check_next   = check_reg;
        x_put        = 1'b0;
        y_put        = 1'b0;
        push         = 1'b0;
        if (accept) begin
            case (phase_reg)
                PH_HEAD: begin
                    if (s_tdata == cfp_pkg::CH_HEAD) begin
                        x_count_next = '0;
                        y_count_next = '0;
                        phase_next   = PH_X;
                    end
                end
                PH_X: begin
                    if (s_tdata == cfp_pkg::CH_SEP) begin
                        phase_next = PH_Y;
                    end else if (x_count_reg < CNT_FULL) begin
                        x_put        = 1'b1;
                        x_count_next = x_count_reg + 1'b1;
                    end else begin
                        x_count_next = CNT_OVER;
                    end
                end
                PH_Y: begin
                    if (s_tdata == cfp_pkg::CH_END) begin
                        phase_next = PH_CHECK;
                    end else if (y_count_reg < CNT_FULL) begin
                        y_put        = 1'b1;
                        y_count_next = y_count_reg + 1'b1;
                    end else begin
                        y_count_next = CNT_OVER;
                    end
                end
                PH_CHECK: begin
                    if (s_tdata == cfp_pkg::CH_TAIL) begin
                        push       = 1'b1;
                        phase_next = PH_HEAD;
                    end else begin
                        check_next = s_tdata;
                    end
                end
                default: begin
                    phase_next = PH_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEAD;
            x_count_reg <= '0;
            y_count_reg <= '0;
            check_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            x_count_reg <= x_count_next;
            y_count_reg <= y_count_next;
            check_reg   <= check_next;
        end
    end

    // store the character at the slot the count points to
    always_ff @(posedge aclk) begin
        for (int i = 0; i < FIELD_DIGITS; i++) begin
            if (x_put && x_count_reg == CNT_W'(i)) begin
                x_chars_reg[i] <= s_tdata;
            end
            if (y_put && y_count_reg == CNT_W'(i)) begin
                y_chars_reg[i] <= s_tdata;
            end
        end
    end

    assign len_ok     = (x_count_reg == CNT_FULL) && (y_count_reg == CNT_FULL);
    assign x_chars    = x_chars_reg;
    assign y_chars    = y_chars_reg;
    assign check_byte = check_reg;

endmodule

// ===== hw/rtl/cfp_fifo.sv =====
// ---------------------------------------------------------------------------
// cfp_fifo: frame record queue
// Two-entry queue between the frame tracker and the evaluator.
// ---------------------------------------------------------------------------
module cfp_fifo #(
    parameter int WIDTH = 57
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   pop_data,
    output cfp_pkg::q_status_t q_stat
);

    logic [1:0][WIDTH-1:0] mem;
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;
    logic                  do_push, do_pop;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];

endmodule

// ===== hw/rtl/cfp_back.sv =====
// ---------------------------------------------------------------------------
// cfp_back: frame evaluator
// Verifies the check byte, converts the fields, keeps the held coordinates
// and the seen flag, and drives the registered result word.
// ---------------------------------------------------------------------------
module cfp_back #(
    parameter int FIELD_DIGITS = 3
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  cfp_pkg::q_status_t                            q_stat,
    output logic                                          pop,
    input  logic                                          len_ok,
    input  logic [FIELD_DIGITS-1:0][cfp_pkg::BYTE_W-1:0]  x_chars,
    input  logic [FIELD_DIGITS-1:0][cfp_pkg::BYTE_W-1:0]  y_chars,
    input  logic [cfp_pkg::BYTE_W-1:0]                    check_byte,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [cfp_pkg::OUT_W-1:0]                     m_tdata
);

    // leading-digit conversion; running value saturates at VALUE_MAX + 1
    function automatic logic [cfp_pkg::VALUE_W-1:0] to_value(
        input logic [FIELD_DIGITS-1:0][cfp_pkg::BYTE_W-1:0] chars
    );
        logic [10:0] v;
        logic [14:0] acc;
        logic        stop;
        v    = '0;
        stop = 1'b0;
        for (int i = 0; i < FIELD_DIGITS; i++) begin
            if (chars[i] < cfp_pkg::CH_ZERO || chars[i] > cfp_pkg::CH_NINE) begin
                stop = 1'b1;
            end
            if (!stop) begin
                acc = 15'(v) * 15'd10 + 15'(chars[i] - cfp_pkg::CH_ZERO);
                v   = (acc > 15'(cfp_pkg::VALUE_MAX)) ? 11'd1024 : acc[10:0];
            end
        end
        return (v > 11'(cfp_pkg::VALUE_MAX)) ? cfp_pkg::VALUE_MAX : v[9:0];
    endfunction

    logic [cfp_pkg::VALUE_W-1:0] x_held_reg, x_held_next;
    logic [cfp_pkg::VALUE_W-1:0] y_held_reg, y_held_next;
    logic                        seen_reg, seen_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        ok_reg;
    logic                        ok;
    logic signed [10:0]          sum;
    logic [8:0]                  mag;
    logic [16:0]                 prod;
    logic [5:0]                  quo;
    logic [3:0]                  rem;
    logic [8:0]                  want;
    logic [cfp_pkg::VALUE_W-1:0] x_conv, y_conv;

    assign pop = !q_stat.empty && (!m_valid_reg || m_tready);

    // check digit: truncated remainder of (last X char + last Y char - 96) by 10, plus '0'
    always_comb begin
        sum  = $signed({3'b000, x_chars[FIELD_DIGITS-1]})
             + $signed({3'b000, y_chars[FIELD_DIGITS-1]}) - 11'sd96;
        mag  = sum[10] ? 9'(-sum) : sum[8:0];
        prod = 17'(mag) * 17'd205;
        quo  = prod[16:11];
        rem  = 4'(mag - 9'(quo) * 9'd10);
        want = sum[10] ? 9'(cfp_pkg::CH_ZERO) - 9'(rem)
                       : 9'(cfp_pkg::CH_ZERO) + 9'(rem);
        ok   = len_ok && ({1'b0, check_byte} == want);
    end

    assign x_conv = to_value(x_chars);
    assign y_conv = to_value(y_chars);

    always_comb begin
        x_held_next  = x_held_reg;
        y_held_next  = y_held_reg;
        seen_next    = seen_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (pop) begin
            m_valid_next = 1'b1;
            if (ok) begin
                x_held_next = x_conv;
                y_held_next = y_conv;
                seen_next   = (x_conv != '0) || (y_conv != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_held_reg  <= '0;
            y_held_reg  <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            x_held_reg  <= x_held_next;
            y_held_reg  <= y_held_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            ok_reg <= ok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, seen_reg, y_held_reg, x_held_reg, ok_reg};

endmodule
